[src/oblivious_tree_ensemble_score_core_assert.svh]
// Assertion macros shared by the checker modules of the tree ensemble scorer.
// Depends on nothing; the including scope supplies clk_i and rst_ni for OTES_CHECK.
`ifndef OBLIVIOUS_TREE_ENSEMBLE_SCORE_CORE_ASSERT_SVH
`define OBLIVIOUS_TREE_ENSEMBLE_SCORE_CORE_ASSERT_SVH

// General form with an explicit clock and active-low reset.
`define OTES_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Short form for scopes that carry clk_i and rst_ni.
`define OTES_CHECK(name, prop) `OTES_ASSERT(name, clk_i, rst_ni, prop)

`endif

[src/otes_pkg.sv]
// Shared types and constants of the oblivious tree ensemble scorer.
// No dependencies; every other file but the assertion header imports this package.
package otes_pkg;

  localparam int TREES_DEF = 64;
  localparam int DEPTH_DEF = 6;
  localparam int FEAT_DEF  = 64;
  localparam int VALW_DEF  = 32;

  // Field widths of the internal buses, sized for the largest parameter values.
  localparam int TREE_W = 10;
  localparam int PATH_W = 12;
  localparam int FEAT_W = 12;
  localparam int DATA_W = 32;
  localparam int LVL_W  = 4;
  localparam int PRED_W = 48;

  localparam logic [2:0] RESET_DEPTH = 3'd6;

  typedef enum logic [2:0] {
    KIND_FEATURE = 3'd0,
    KIND_THRESH  = 3'd1,
    KIND_LEAF    = 3'd2,
    KIND_COMMIT  = 3'd3,
    KIND_POP     = 3'd4,
    KIND_SAMPLE  = 3'd5
  } kind_e;

  typedef struct packed {
    logic              valid;
    logic [TREE_W-1:0] tree;
    logic [PATH_W-1:0] path;
  } walk_t;

  typedef struct packed {
    logic              feat_we;
    logic              thr_we;
    logic              smp_we;
    logic              leaf_we;
    logic [LVL_W-1:0]  lvl;
    logic [TREE_W-1:0] tree;
    logic [PATH_W-1:0] idx;
    logic [FEAT_W-1:0] feat;
    logic [DATA_W-1:0] data;
  } wr_t;

endpackage

[src/otes_if.sv]
// Channel interfaces of the tree ensemble scorer: requests, results, configuration.
// Depends on otes_pkg for the output width.
interface otes_in_if import otes_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [5:0]  slot_index;
  logic [31:0] value;
  logic [6:0]  first_tree;
  logic [6:0]  end_tree;
  logic        last_element;

  modport source (output valid, kind, slot_index, value, first_tree, end_tree, last_element,
                  input ready);
  modport sink (input valid, kind, slot_index, value, first_tree, end_tree, last_element,
                output ready);
endinterface

interface otes_out_if import otes_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PRED_W-1:0] prediction;
  logic [6:0]        trees_held;
  logic              status;

  modport source (output valid, prediction, trees_held, status, input ready);
  modport sink (input valid, prediction, trees_held, status, output ready);
endinterface

interface otes_cfg_if ();
  logic       valid;
  logic       ready;
  logic [2:0] tree_depth;

  modport source (output valid, tree_depth, input ready);
  modport sink (input valid, tree_depth, output ready);
endinterface

[src/otes_level_cell.sv]
// One tree level of the scoring chain: feature, threshold and sample stores plus compare.
// Depends on otes_pkg.
module otes_level_cell import otes_pkg::*; #(
  parameter int LEVEL        = 0,
  parameter int MAX_TREES    = TREES_DEF,
  parameter int MAX_FEATURES = FEAT_DEF,
  parameter int VALUE_WIDTH  = VALW_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LVL_W-1:0] depth_i,
  input  wr_t              wr_i,
  input  walk_t            walk_i,
  output walk_t            walk_o
);

  localparam int TW    = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int IW    = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int NODES = MAX_TREES << LEVEL;
  localparam int AW    = (NODES > 1) ? $clog2(NODES) : 1;

  logic [FW-1:0] feat_mem [MAX_TREES];
  logic [IW-1:0] thr_mem  [NODES];
  logic [IW-1:0] smp_mem  [MAX_FEATURES];

  logic [FW-1:0] feat_q;
  logic [IW-1:0] thr1_q, thr2_q, smp_q;
  walk_t         w1_q, w2_q, w3_q, w3_d;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          lvl_hit, go_right;

  assign lvl_hit = (wr_i.lvl == LVL_W'(LEVEL));
  assign rd_addr = (AW'(walk_i.tree[TW-1:0]) << LEVEL) | AW'(walk_i.path);
  assign wr_addr = (AW'(wr_i.tree[TW-1:0]) << LEVEL) | AW'(wr_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_i.feat_we && lvl_hit) begin
      feat_mem[wr_i.tree[TW-1:0]] <= wr_i.feat[FW-1:0];
    end
    feat_q <= feat_mem[walk_i.tree[TW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.thr_we && lvl_hit) begin
      thr_mem[wr_addr] <= wr_i.data[IW-1:0];
    end
    thr1_q <= thr_mem[rd_addr];
  end

  // Every cell keeps its own copy of the sample so that all levels read in parallel.
  always_ff @(posedge clk_i) begin
    if (wr_i.smp_we) begin
      smp_mem[wr_i.idx[FW-1:0]] <= wr_i.data[IW-1:0];
    end
    smp_q  <= smp_mem[feat_q];
    thr2_q <= thr1_q;
  end

  assign go_right = !($signed(smp_q) < $signed(thr2_q));

  always_comb begin
    w3_d = w2_q;
    if (LVL_W'(LEVEL) < depth_i) begin
      w3_d.path = {w2_q.path[PATH_W-2:0], go_right};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= '0;
      w2_q <= '0;
      w3_q <= '0;
    end else begin
      w1_q <= walk_i;
      w2_q <= w1_q;
      w3_q <= w3_d;
    end
  end

  assign walk_o = w3_q;

endmodule

[src/otes_leaf_cell.sv]
// Last cell of the scoring chain: leaf store and the prediction accumulator.
// Depends on otes_pkg.
module otes_leaf_cell import otes_pkg::*; #(
  parameter int MAX_TREES   = TREES_DEF,
  parameter int MAX_DEPTH   = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  wr_t               wr_i,
  input  walk_t             walk_i,
  output logic [PRED_W-1:0] sum_o
);

  localparam int TW     = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int IW     = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int LEAVES = MAX_TREES << MAX_DEPTH;
  localparam int AW     = $clog2(LEAVES);

  logic [IW-1:0]     leaf_mem [LEAVES];
  logic [IW-1:0]     leaf_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              hit_q;
  logic [PRED_W-1:0] acc_q;

  assign rd_addr = (AW'(walk_i.tree[TW-1:0]) << MAX_DEPTH) | AW'(walk_i.path);
  assign wr_addr = (AW'(wr_i.tree[TW-1:0]) << MAX_DEPTH) | AW'(wr_i.idx);

  always_ff @(posedge clk_i) begin
    if (wr_i.leaf_we) begin
      leaf_mem[wr_addr] <= wr_i.data[IW-1:0];
    end
    leaf_q <= leaf_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      acc_q <= '0;
    end else begin
      hit_q <= walk_i.valid;
      if (clear_i) begin
        acc_q <= '0;
      end else if (hit_q) begin
        acc_q <= acc_q + {{(PRED_W-IW){leaf_q[IW-1]}}, leaf_q};
      end
    end
  end

  assign sum_o = acc_q;

endmodule

[src/oblivious_tree_ensemble_score_core.sv]
// Top level of the oblivious tree ensemble scorer: request decode, sequencer, cell chain.
// Depends on otes_pkg, otes_if, otes_level_cell and otes_leaf_cell.
//
// Requests arrive on in_ch. Feature, threshold and leaf requests write the tables of
// the next free tree slot, commit and pop move the tree stack, and sample requests
// fill the sample store. A sample request marked last starts scoring and yields one
// result on out_ch; no other request yields one. cfg_ch sets the depth in use and is
// always ready; write it only while the block is idle.
// Threshold, leaf, commit, pop and unmarked sample requests leave the block idle. A feature
// request holds it in ST_MOD: its index is reduced modulo MAX_FEATURES by a reciprocal
// multiplication and, in the cycle after, a multiply and subtract.
// Scoring walks the trees from first up to end, with end clamped to the tree count and
// no tree walked when first is not below it; the block takes no further request until
// the result is registered. One tree enters the chain of level cells per cycle and each
// level cell registers its feature, sample and threshold reads before the compare.
// Reset empties the tree stack and sets the depth to six; table contents are left
// undefined. A result waits in the output register while the receiver stalls; further
// requests are taken meanwhile, but after a second scoring request the block holds until it is taken.
module oblivious_tree_ensemble_score_core import otes_pkg::*; #(
  parameter int MAX_TREES    = TREES_DEF,
  parameter int MAX_DEPTH    = DEPTH_DEF,
  parameter int MAX_FEATURES = FEAT_DEF,
  parameter int VALUE_WIDTH  = VALW_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  otes_in_if.sink    in_ch,
  otes_cfg_if.sink   cfg_ch,
  otes_out_if.source out_ch
);

  localparam int CW        = $clog2(MAX_TREES + 1);
  localparam int PW        = (CW > 7) ? CW : 7;
  localparam int FW        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int INNER_MAX = (1 << MAX_DEPTH) - 1;
  localparam int LEAF_MAX  = 1 << MAX_DEPTH;
  localparam int LAT       = 3 * MAX_DEPTH + 2;
  localparam int DW        = $clog2(LAT + 1);
  // Rounded-up reciprocal: the quotient of any 32-bit index comes out exact.
  localparam int          REC_SH = 32 + FW;
  localparam logic [63:0] RECIP  = ((64'd1 << REC_SH) + 64'(MAX_FEATURES) - 64'd1) /
                                   64'(MAX_FEATURES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_ISSUE = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [2:0]        depth_q;
  logic [LVL_W-1:0]  depth_use;
  wr_t               wr_q, wr_d;
  logic [PW-1:0]     ptr_q, ptr_d, end_q, end_d;
  logic [DW-1:0]     drain_q, drain_d;
  logic              stat_q, stat_d;
  logic [31:0]       x_q, x_d;
  logic [31:0]       q_q, q_d;
  logic [2:0]        step_q, step_d;
  logic [LVL_W-1:0]  flvl_q, flvl_d;
  logic [TREE_W-1:0] ftree_q, ftree_d;
  logic              clear;
  logic              oval_q, oval_d;
  logic [PRED_W-1:0] pred_q, pred_d;
  logic [6:0]        held_q, held_d;
  logic              ostat_q, ostat_d;
  logic [PRED_W-1:0] sum;
  walk_t             issue_walk;
  walk_t             chain [MAX_DEPTH+1];
  logic              accept, room;
  logic [6:0]        s1;
  logic [2:0]        hbit;
  logic [PW-1:0]     endc;

  assign accept = in_ch.valid && in_ch.ready;
  assign room   = (cnt_q < CW'(MAX_TREES));
  assign in_ch.ready = (state_q == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign depth_use = (depth_q == 3'd0) ? LVL_W'(1) :
                     ((LVL_W'(depth_q) > LVL_W'(MAX_DEPTH)) ? LVL_W'(MAX_DEPTH)
                                                           : LVL_W'(depth_q));

  // Heap index of a threshold split into level (top set bit of index+1) and offset.
  always_comb begin
    s1   = {1'b0, in_ch.slot_index} + 7'd1;
    hbit = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (s1[i]) hbit = 3'(i);
    end
  end

  assign endc = (PW'(in_ch.end_tree) > PW'(cnt_q)) ? PW'(cnt_q) : PW'(in_ch.end_tree);

  assign chain[0] = issue_walk;

  always_comb begin
    logic [64:0] prod;
    logic [31:0] rem;
    state_d = state_q;
    cnt_d   = cnt_q;
    wr_d    = '0;
    ptr_d   = ptr_q;
    end_d   = end_q;
    drain_d = drain_q;
    stat_d  = stat_q;
    x_d     = x_q;
    q_d     = q_q;
    step_d  = step_q;
    flvl_d  = flvl_q;
    ftree_d = ftree_q;
    clear   = 1'b0;
    oval_d  = oval_q && !out_ch.ready;
    pred_d  = pred_q;
    held_d  = held_q;
    ostat_d = ostat_q;
    issue_walk = '0;
    prod = 65'(x_q) * 65'(RECIP);
    rem  = x_q - 32'(64'(q_q) * 64'(MAX_FEATURES));

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind_e'(in_ch.kind))
            KIND_FEATURE: begin
              if (room && (32'(in_ch.slot_index) < MAX_DEPTH)) begin
                x_d     = in_ch.value;
                step_d  = '0;
                flvl_d  = LVL_W'(in_ch.slot_index);
                ftree_d = TREE_W'(cnt_q);
                state_d = ST_MOD;
              end
            end
            KIND_THRESH: begin
              if (room && (32'(in_ch.slot_index) < INNER_MAX)) begin
                wr_d.thr_we = 1'b1;
                wr_d.lvl    = LVL_W'(hbit);
                wr_d.tree   = TREE_W'(cnt_q);
                wr_d.idx    = PATH_W'(s1 ^ (7'd1 << hbit));
                wr_d.data   = in_ch.value;
              end
            end
            KIND_LEAF: begin
              if (room && (32'(in_ch.slot_index) < LEAF_MAX)) begin
                wr_d.leaf_we = 1'b1;
                wr_d.tree    = TREE_W'(cnt_q);
                wr_d.idx     = PATH_W'(in_ch.slot_index);
                wr_d.data    = in_ch.value;
              end
            end
            KIND_COMMIT: begin
              if (room) cnt_d = cnt_q + CW'(1);
            end
            KIND_POP: begin
              if (cnt_q != '0) cnt_d = cnt_q - CW'(1);
            end
            KIND_SAMPLE: begin
              if (32'(in_ch.slot_index) < MAX_FEATURES) begin
                wr_d.smp_we = 1'b1;
                wr_d.idx    = PATH_W'(in_ch.slot_index);
                wr_d.data   = in_ch.value;
              end
              if (in_ch.last_element) begin
                clear   = 1'b1;
                ptr_d   = PW'(in_ch.first_tree);
                end_d   = endc;
                stat_d  = (PW'(in_ch.end_tree) > PW'(cnt_q));
                state_d = ST_ISSUE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd0) begin
          q_d = 32'(prod >> REC_SH);
        end else begin
          wr_d.feat_we = 1'b1;
          wr_d.lvl     = flvl_q;
          wr_d.tree    = ftree_q;
          wr_d.feat    = FEAT_W'(rem);
          state_d      = ST_IDLE;
        end
      end
      ST_ISSUE: begin
        if (ptr_q < end_q) begin
          issue_walk.valid = 1'b1;
          issue_walk.tree  = TREE_W'(ptr_q);
          ptr_d            = ptr_q + PW'(1);
        end else begin
          drain_d = DW'(LAT);
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q == '0) begin
          state_d = ST_DONE;
        end else begin
          drain_d = drain_q - DW'(1);
        end
      end
      ST_DONE: begin
        if (!oval_q || out_ch.ready) begin
          oval_d  = 1'b1;
          pred_d  = sum;
          held_d  = 7'(cnt_q);
          ostat_d = stat_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      depth_q <= RESET_DEPTH;
      wr_q    <= '0;
      oval_q  <= 1'b0;
      ptr_q   <= '0;
      end_q   <= '0;
      drain_q <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      wr_q    <= wr_d;
      oval_q  <= oval_d;
      ptr_q   <= ptr_d;
      end_q   <= end_d;
      drain_q <= drain_d;
      step_q  <= step_d;
      if (cfg_ch.valid) depth_q <= cfg_ch.tree_depth;
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q  <= stat_d;
    x_q     <= x_d;
    q_q     <= q_d;
    flvl_q  <= flvl_d;
    ftree_q <= ftree_d;
    pred_q  <= pred_d;
    held_q  <= held_d;
    ostat_q <= ostat_d;
  end

  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_level
    otes_level_cell #(
      .LEVEL        (g),
      .MAX_TREES    (MAX_TREES),
      .MAX_FEATURES (MAX_FEATURES),
      .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .depth_i (depth_use),
      .wr_i    (wr_q),
      .walk_i  (chain[g]),
      .walk_o  (chain[g+1])
    );
  end

  otes_leaf_cell #(
    .MAX_TREES   (MAX_TREES),
    .MAX_DEPTH   (MAX_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_leaf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .wr_i    (wr_q),
    .walk_i  (chain[MAX_DEPTH]),
    .sum_o   (sum)
  );

  assign out_ch.valid      = oval_q;
  assign out_ch.prediction = pred_q;
  assign out_ch.trees_held = held_q;
  assign out_ch.status     = ostat_q;

endmodule

[src/otes_checker.sv]
// Port-level checks of the tree ensemble scorer and their bind to the top level.
// Depends on otes_pkg and oblivious_tree_ensemble_score_core_assert.svh.
`include "oblivious_tree_ensemble_score_core_assert.svh"

module otes_checker import otes_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid,
  input logic              in_ready,
  input logic [2:0]        kind,
  input logic              last_element,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PRED_W-1:0] prediction
);

  // A held result keeps its value until it is taken.
  `OTES_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(prediction))

  // A scoring request occupies the block in the following cycle.
  `OTES_CHECK(a_score_busy, in_valid && in_ready && kind == KIND_SAMPLE && last_element |=> !in_ready)

  // Only scoring requests may produce a result.
  `OTES_CHECK(a_no_spurious, in_valid && in_ready && kind != KIND_SAMPLE |=> !$rose(out_valid))

endmodule

bind oblivious_tree_ensemble_score_core otes_checker u_otes_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .kind         (in_ch.kind),
  .last_element (in_ch.last_element),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .prediction   (out_ch.prediction)
);

[dv/oblivious_tree_ensemble_score_core_tb.sv]
// Testbench of the oblivious tree ensemble scorer: builds trees, scores samples, and checks
// each result against a behavioural predictor. Depends on otes_pkg, otes_if and the core RTL.
module oblivious_tree_ensemble_score_core_tb;
  import otes_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTREE = 64;
  localparam int NDEPTH = 6;
  localparam int NFEAT = 64;
  localparam int NINNER = 63;
  localparam int NLEAF = 64;

  typedef struct packed {
    logic [PRED_W-1:0] prediction;
    logic [6:0]        trees_held;
    logic              status;
  } score_t;

  class score_board;
    logic [31:0] samples[NFEAT];
    logic [5:0]  feats[NTREE*NDEPTH];
    logic [31:0] thrs[NTREE*NINNER];
    logic [31:0] leaves[NTREE*NLEAF];
    int unsigned n_trees;
    logic [2:0]  depth;
    score_t      pending[$];
    int          errors;
    int          scored;

    function new();
      n_trees = 0;
      depth = RESET_DEPTH;
      errors = 0;
      scored = 0;
      foreach (samples[i]) samples[i] = '0;
      foreach (feats[i]) feats[i] = '0;
      foreach (thrs[i]) thrs[i] = '0;
      foreach (leaves[i]) leaves[i] = '0;
    endfunction

    function void note_request(logic [2:0] kind, logic [5:0] slot, logic [31:0] val,
                               logic [6:0] first, logic [6:0] stop, logic last);
      int unsigned d, node, hi;
      logic [PRED_W-1:0] sum;
      score_t r;
      logic room;
      room = n_trees < NTREE;
      case (kind)
        KIND_FEATURE: if (room && slot < NDEPTH) feats[n_trees*NDEPTH + slot] = val[5:0];
        KIND_THRESH:  if (room && slot < NINNER) thrs[n_trees*NINNER + slot] = val;
        KIND_LEAF:    if (room) leaves[n_trees*NLEAF + slot] = val;
        KIND_COMMIT:  if (room) n_trees++;
        KIND_POP:     if (n_trees > 0) n_trees--;
        KIND_SAMPLE: begin
          samples[slot] = val;
          if (last) begin
            d = (depth == 0) ? 1 : (depth > NDEPTH ? NDEPTH : depth);
            hi = stop;
            r.status = 1'b0;
            if (hi > n_trees) begin
              hi = n_trees;
              r.status = 1'b1;
            end
            sum = '0;
            for (int unsigned t = first; t < hi; t++) begin
              node = 0;
              for (int unsigned h = 0; h < d; h++) begin
                if ($signed(samples[feats[t*NDEPTH+h]]) < $signed(thrs[t*NINNER+node]))
                  node = 2*node + 1;
                else
                  node = 2*node + 2;
              end
              sum = sum + {{(PRED_W-32){leaves[t*NLEAF + node - ((1<<d)-1)][31]}},
                           leaves[t*NLEAF + node - ((1<<d)-1)]};
            end
            r.prediction = sum;
            r.trees_held = n_trees[6:0];
            pending = {pending, r};
          end
        end
        default: ;
      endcase
    endfunction

    function void check_score(score_t got);
      score_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result: prediction %0h", got.prediction);
        errors++;
        return;
      end
      exp = pending.pop_front();
      scored++;
      if (got.prediction !== exp.prediction) begin
        $error("prediction: expected %0h, actual %0h", exp.prediction, got.prediction);
        errors++;
      end
      if (got.trees_held !== exp.trees_held) begin
        $error("trees_held: expected %0d, actual %0d", exp.trees_held, got.trees_held);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  otes_in_if  in_ch();
  otes_out_if out_ch();
  otes_cfg_if cfg_ch();

  oblivious_tree_ensemble_score_core u_dut (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_ch (in_ch), .cfg_ch (cfg_ch), .out_ch (out_ch)
  );

  score_board sb = new();
  int send_idle, recv_stall;
  int n_sent;
  // Deepest level to which each tree slot has been fully written; walks never go deeper.
  int unsigned slot_depth[NTREE];
  int unsigned model_trees;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // Receiver: random stalls; results checked at the accepting edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_score({out_ch.prediction, out_ch.trees_held, out_ch.status});
      out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // The request stays on the bus after it is taken; the next request or an idle cycle
  // replaces it, and every task that waits drops valid first.
  task automatic send_req(logic [2:0] kind, logic [5:0] slot, logic [31:0] val,
                          logic [6:0] first = 0, logic [6:0] stop = 0, logic last = 0);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.slot_index <= slot;
    in_ch.value <= val;
    in_ch.first_tree <= first;
    in_ch.end_tree <= stop;
    in_ch.last_element <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_request(kind, slot, val, first, stop, last);
    if (kind == KIND_COMMIT && model_trees < NTREE) model_trees++;
    if (kind == KIND_POP && model_trees > 0) model_trees--;
    n_sent++;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned depth_in_use(logic [2:0] d);
    return (d == 3'd0) ? 1 : ((d > NDEPTH) ? NDEPTH : int'(d));
  endfunction

  // True when every tree the range walks has been written at least to depth du.
  function automatic bit range_ok(int unsigned f, int unsigned s, int unsigned du);
    int unsigned hi;
    hi = (s > model_trees) ? model_trees : s;
    for (int unsigned t = f; t < hi; t++)
      if (slot_depth[t] < du) return 1'b0;
    return 1'b1;
  endfunction

  // Tree of ld levels into the next free slot, then commit.
  task automatic load_tree(int unsigned ld);
    if (model_trees >= NTREE) return;
    for (int h = 0; h < ld; h++) send_req(KIND_FEATURE, 6'(h), $urandom());
    for (int n = 0; n < (1 << ld) - 1; n++) send_req(KIND_THRESH, 6'(n), rand_val());
    for (int l = 0; l < (1 << ld); l++) send_req(KIND_LEAF, 6'(l), rand_val());
    if (ld > slot_depth[model_trees]) slot_depth[model_trees] = ld;
    send_req(KIND_COMMIT, 6'($urandom()), $urandom());
  endtask

  // A few sample updates, the final element triggering a score.
  task automatic score_sample(logic [6:0] first, logic [6:0] stop);
    for (int f = 0; f < NFEAT - 1; f++)
      if ($urandom_range(15) == 0)
        send_req(KIND_SAMPLE, 6'(f), rand_val(), 7'($urandom()), 7'($urandom()));
    send_req(KIND_SAMPLE, 63, rand_val(), first, stop, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (6*NDEPTH + NTREE + 20) @(posedge clk_i);
  endtask

  task automatic write_depth(logic [2:0] d);
    in_ch.valid <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.tree_depth <= d;
    do @(posedge clk_i); while (!cfg_ch.ready);
    sb.depth = d;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_phase(int p);
    case (p % 4)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 48; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 48; end
      default: begin send_idle = 11; recv_stall = 11; end
    endcase
  endtask

  initial begin
    int unsigned first, stop, du, top;
    send_idle = 0;
    recv_stall = 0;
    n_sent = 0;
    model_trees = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SAMPLE;
    in_ch.slot_index = '0;
    in_ch.value = '0;
    in_ch.first_tree = '0;
    in_ch.end_tree = '0;
    in_ch.last_element = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.tree_depth = RESET_DEPTH;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full sample, empty stack, pop on empty, idle kinds, clamped range, out-of-range slots.
    for (int f = 0; f < NFEAT; f++) send_req(KIND_SAMPLE, 6'(f), rand_val());
    send_req(KIND_POP, 0, 0);
    send_req(3'd6, 6'h3f, 32'hffff_ffff, 7'h7f, 7'h7f, 1'b1);
    send_req(3'd7, 0, 0, 0, 0, 1'b1);
    send_req(KIND_SAMPLE, 0, 32'h8000_0000, 0, 64, 1'b1);
    send_req(KIND_FEATURE, 6'h3f, 32'hffff_ffff);
    send_req(KIND_THRESH, 6'h3f, 32'h1234_5678);
    load_tree(NDEPTH);
    score_sample(0, 1);
    score_sample(1, 1);
    score_sample(1, 0);
    score_sample(0, 127);
    send_req(KIND_POP, 0, 0);
    score_sample(0, 2);
    // The popped slot keeps its tables, so a bare commit brings the tree back.
    send_req(KIND_COMMIT, 0, 0);
    score_sample(0, 1);
    drain();

    // Random: phases of depth and idling, trees pushed and popped, samples scored.
    for (int p = 0; p < 8; p++) begin
      set_phase(p);
      write_depth(p == 0 ? 3'd0 : (p == 1 ? 3'd7 : (p == 2 ? 3'd1 : 3'($urandom_range(7)))));
      du = depth_in_use(sb.depth);
      load_tree($urandom_range(3, 1));
      if ($urandom_range(3) == 0) send_req(KIND_POP, 6'($urandom()), $urandom());
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 8; k++) begin
          first = $urandom_range(model_trees + 1);
          stop = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(model_trees);
          if (range_ok(first, stop, du)) break;
        end
        if (!range_ok(first, stop, du)) begin
          first = 0;
          stop = range_ok(0, 1, du) ? 1 : 0;
        end
        score_sample(7'(first), 7'(stop));
      end
      drain();
    end
    // Fill the stack to its top and press against it.
    set_phase(0);
    while (model_trees < NTREE) send_req(KIND_COMMIT, 0, 0);
    send_req(KIND_LEAF, 0, 32'h1);
    send_req(KIND_COMMIT, 0, 0);
    write_depth(3'd1);
    top = 0;
    while (top < NTREE && slot_depth[top] != 0) top++;
    score_sample(0, 7'(top));
    drain();

    $display("Sent %0d requests and checked %0d scores over depths 0..7 and four idling mixes.",
             n_sent, sb.scored);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/otes_pkg.sv
src/otes_if.sv
src/otes_level_cell.sv
src/otes_leaf_cell.sv
src/oblivious_tree_ensemble_score_core.sv
src/otes_checker.sv
dv/oblivious_tree_ensemble_score_core_tb.sv
